// ===== rtl/dctq_pkg.sv =====
// Shared types and codes of the delayed callback timer queue.
// No dependencies; used by the top level and by dctq_eval.
package dctq_pkg;

    // Command codes on the request channel.
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // Result codes.
    localparam logic [2:0] EV_QUEUED  = 3'd0;
    localparam logic [2:0] EV_FIRED   = 3'd1;
    localparam logic [2:0] EV_DUP     = 3'd2;
    localparam logic [2:0] EV_FULL    = 3'd3;
    localparam logic [2:0] EV_REMOVED = 3'd4;

    // At most this many expiries go out on one tick.
    localparam int unsigned MAX_FIRE = 16;
    // removed_count saturates here.
    localparam int unsigned RM_SAT   = 31;

    localparam logic signed [31:0] REM_MIN = 32'sh8000_0000;

    // One stored timer entry.
    typedef struct packed {
        logic [15:0]        handler;
        logic [31:0]        ctx;
        logic signed [31:0] remaining;
        logic               fresh;
    } slot_t;

    // Outcome of evaluating one entry against the current request.
    typedef struct packed {
        logic               key_match;
        logic               due;
        logic signed [31:0] remaining;
    } eval_t;

endpackage

// ===== rtl/delayed_callback_timer_queue_top.sv =====
// Delayed callback timer queue: top level with the slot walk sequencer.
// Depends on dctq_pkg, dctq_ram and dctq_eval.
//
// Usage:
//   Request channel (cmd_valid / cmd_stall) takes add, remove and tick beats.
//   Result channel (res_valid / res_stall) returns result beats; last marks
//   the final beat caused by one request. Add and remove always give one
//   beat; a tick gives one beat per fired timer, or none.
//   Timing: every request but an add with delay <= 0 walks the stored
//   entries through one RAM read port and one shared compare/countdown
//   unit. The final result beat is loaded once the walk ends (a duplicate add
//   stops at the matching entry), and the next request is taken in the
//   cycle after; a tick that fires nothing is done when its walk ends.
//   cmd_stall is high from acceptance until the last result beat of the
//   request has entered the output register. While the receiver holds
//   res_stall on a full output register, a tick walk holds at a due entry
//   while a fired beat is pending, and the closing beat and cmd_stall hold.
//   Reset empties the pool at once (entry count cleared) and drops any
//   pending result. A stalled result beat holds its value.
module delayed_callback_timer_queue_top #(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  cmd,
    input  logic [15:0] handler_id,
    input  logic [31:0] context_req,
    input  logic signed [31:0] delay,
    input  logic        ignore_context,
    input  logic [30:0] elapsed,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [2:0]  event_res,
    output logic [15:0] fired_handler,
    output logic [31:0] fired_context,
    output logic [4:0]  removed_count,
    output logic        last
);
    import dctq_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int RM_W  = (CNT_W > 5) ? CNT_W : 5;
    localparam int FIRE_W = $clog2(MAX_FIRE + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RD    = 5'b00010,
        S_EV    = 5'b00100,
        S_RESP  = 5'b01000,
        S_FLUSH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]  rm_reg, rm_next;
    logic [FIRE_W-1:0] fire_reg, fire_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              res_valid_reg;

    // request held for the walk
    logic [1:0]         cmd_reg;
    logic [15:0]        h_reg;
    logic [31:0]        c_reg;
    logic signed [31:0] delay_reg;
    logic               ign_reg;
    logic [30:0]        el_reg;
    logic [2:0]         rsp_reg, rsp_next;

    // oldest fired timer not yet sent
    logic [15:0] pend_h_reg;
    logic [31:0] pend_c_reg;
    logic        pend_load;

    // output register payload
    logic [2:0]  ev_out_reg;
    logic [15:0] h_out_reg;
    logic [31:0] c_out_reg;
    logic [4:0]  rm_out_reg;
    logic        last_out_reg;

    logic        out_load;
    logic [2:0]  ev_out_next;
    logic [15:0] h_out_next;
    logic [31:0] c_out_next;
    logic [4:0]  rm_out_next;
    logic        last_out_next;

    logic        accept;
    logic        out_free;
    logic        ram_we;
    logic [IDX_W-1:0] ram_waddr;
    slot_t       ram_wdata;
    slot_t       ram_rdata;
    eval_t       ev;
    logic        eval_ign;
    logic [RM_W-1:0] rm_ext;
    logic [4:0]  rm_sat;

    assign accept    = cmd_valid && (state_reg == S_IDLE);
    assign cmd_stall = (state_reg != S_IDLE);
    assign out_free  = !res_valid_reg || !res_stall;
    assign eval_ign  = ign_reg && (cmd_reg == CMD_REMOVE);

    assign rm_ext = RM_W'(rm_reg);
    assign rm_sat = (rm_ext > RM_W'(RM_SAT)) ? 5'(RM_SAT) : rm_ext[4:0];

    dctq_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    dctq_eval u_eval (
        .slot           (ram_rdata),
        .handler_id     (h_reg),
        .context_req    (c_reg),
        .ignore_context (eval_ign),
        .elapsed        (el_reg),
        .result         (ev)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        rm_next         = rm_reg;
        fire_next       = fire_reg;
        pend_valid_next = pend_valid_reg;
        rsp_next        = rsp_reg;
        pend_load       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = wr_idx_reg[IDX_W-1:0];
        ram_wdata       = ram_rdata;
        out_load        = 1'b0;
        ev_out_next     = EV_FIRED;
        h_out_next      = pend_h_reg;
        c_out_next      = pend_c_reg;
        rm_out_next     = 5'd0;
        last_out_next   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    rd_idx_next = '0;
                    wr_idx_next = '0;
                    rm_next     = '0;
                    fire_next   = '0;
                    case (cmd)
                        CMD_ADD:
                        begin
                            if (delay[31] || (delay == 32'sd0))
                            begin
                                rsp_next   = EV_FIRED;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        CMD_REMOVE, CMD_TICK:
                        begin
                            state_next = S_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                if (rd_idx_reg == cnt_reg)
                begin
                    // walk done: close out the request
                    case (cmd_reg)
                        CMD_ADD:
                        begin
                            if (cnt_reg == CNT_W'(SLOTS))
                            begin
                                rsp_next = EV_FULL;
                            end
                            else
                            begin
                                ram_we              = 1'b1;
                                ram_waddr           = cnt_reg[IDX_W-1:0];
                                ram_wdata.handler   = h_reg;
                                ram_wdata.ctx       = c_reg;
                                ram_wdata.remaining = delay_reg;
                                ram_wdata.fresh     = 1'b1;
                                cnt_next            = cnt_reg + 1'b1;
                                rsp_next            = EV_QUEUED;
                            end
                            state_next = S_RESP;
                        end
                        CMD_REMOVE:
                        begin
                            cnt_next   = wr_idx_reg;
                            rsp_next   = EV_REMOVED;
                            state_next = S_RESP;
                        end
                        default:
                        begin
                            cnt_next   = wr_idx_reg;
                            state_next = pend_valid_reg ? S_FLUSH : S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    state_next = S_EV;
                end
            end

            S_EV:
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (ev.key_match)
                        begin
                            rsp_next   = EV_DUP;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            rd_idx_next = rd_idx_reg + 1'b1;
                            state_next  = S_RD;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (ev.key_match)
                        begin
                            rm_next = rm_reg + 1'b1;
                        end
                        else
                        begin
                            // compact: keep the entry at the write index
                            ram_we      = 1'b1;
                            wr_idx_next = wr_idx_reg + 1'b1;
                        end
                        rd_idx_next = rd_idx_reg + 1'b1;
                        state_next  = S_RD;
                    end
                    default:
                    begin
                        if (ev.due && (fire_reg < FIRE_W'(MAX_FIRE)))
                        begin
                            // hold while the earlier fired beat cannot move out
                            if (!pend_valid_reg || out_free)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_load = 1'b1;
                                end
                                pend_load       = 1'b1;
                                pend_valid_next = 1'b1;
                                fire_next       = fire_reg + 1'b1;
                                rd_idx_next     = rd_idx_reg + 1'b1;
                                state_next      = S_RD;
                            end
                        end
                        else
                        begin
                            ram_we              = 1'b1;
                            ram_wdata.remaining = ev.remaining;
                            ram_wdata.fresh     = 1'b0;
                            wr_idx_next         = wr_idx_reg + 1'b1;
                            rd_idx_next         = rd_idx_reg + 1'b1;
                            state_next          = S_RD;
                        end
                    end
                endcase
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    ev_out_next   = rsp_reg;
                    h_out_next    = h_reg;
                    c_out_next    = c_reg;
                    rm_out_next   = rm_sat;
                    last_out_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    last_out_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            rm_reg         <= '0;
            fire_reg       <= '0;
            pend_valid_reg <= 1'b0;
            rsp_reg        <= EV_QUEUED;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
            rm_reg         <= rm_next;
            fire_reg       <= fire_next;
            pend_valid_reg <= pend_valid_next;
            rsp_reg        <= rsp_next;
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            h_reg     <= handler_id;
            c_reg     <= context_req;
            delay_reg <= delay;
            ign_reg   <= ignore_context;
            el_reg    <= elapsed;
        end
        if (pend_load)
        begin
            pend_h_reg <= ram_rdata.handler;
            pend_c_reg <= ram_rdata.ctx;
        end
        if (out_load)
        begin
            ev_out_reg   <= ev_out_next;
            h_out_reg    <= h_out_next;
            c_out_reg    <= c_out_next;
            rm_out_reg   <= rm_out_next;
            last_out_reg <= last_out_next;
        end
    end

    assign res_valid     = res_valid_reg;
    assign event_res     = ev_out_reg;
    assign fired_handler = h_out_reg;
    assign fired_context = c_out_reg;
    assign removed_count = rm_out_reg;
    assign last          = last_out_reg;

endmodule

// ===== rtl/dctq_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dctq_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/dctq_eval.sv =====
// Shared per-entry unit: key compare and saturating countdown of one slot.
// Depends on dctq_pkg.
module dctq_eval (
    input  dctq_pkg::slot_t slot,
    input  logic [15:0]     handler_id,
    input  logic [31:0]     context_req,
    input  logic            ignore_context,
    input  logic [30:0]     elapsed,
    output dctq_pkg::eval_t result
);
    import dctq_pkg::*;

    logic signed [32:0] diff;
    logic signed [31:0] counted;

    always_comb
    begin
        diff = {slot.remaining[31], slot.remaining} - {2'b00, elapsed};
        // clamp at the most negative value
        if (diff[32] != diff[31])
        begin
            counted = REM_MIN;
        end
        else
        begin
            counted = diff[31:0];
        end

        result.key_match = (slot.handler == handler_id) &&
                           (ignore_context || (slot.ctx == context_req));
        // a fresh entry only loses its fresh mark on this tick
        result.remaining = slot.fresh ? slot.remaining : counted;
        result.due       = !slot.fresh && (counted[31] || (counted == 32'sd0));
    end

endmodule
